FILE: src/lcdw_pkg.sv
// Shared types, codes and constants of the character LCD nibble writer.
package lcdw_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 6;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] REQ_CHAR  = 2'd0;
	localparam logic [1:0] REQ_MOVE  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = CFG_IDX_W'(1);

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_DDRAM    = 8'h80;

	localparam logic [2:0] ROW_COUNT_RST    = 3'd2;
	localparam logic [5:0] COLUMN_COUNT_RST = 6'd16;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_code;
		logic [5:0] target_column;
		logic [1:0] target_row;
	} req_t;

	typedef struct packed {
		logic       reg_select;
		logic [3:0] bus_nibble;
		logic       last_nibble;
	} res_t;

	// One or two bus bytes; the second one is always a command.
	typedef struct packed {
		logic       two;
		logic       rs0;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} job_t;

	function automatic logic [6:0] row_base(input logic [1:0] row);
		logic [6:0] base;
		case (row)
			2'd0:    base = 7'h00;
			2'd1:    base = 7'h40;
			2'd2:    base = 7'h14;
			2'd3:    base = 7'h54;
			default: base = 7'h00;
		endcase
		return base;
	endfunction

endpackage

FILE: src/lcdw_front.sv
// Front end: configuration registers, cursor tracking and request classification.
module lcdw_front import lcdw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_vld,
	input  req_t                  req,
	output logic                  job_vld,
	output job_t                  job
);

	logic [2:0] row_count_q;
	logic [5:0] column_count_q;
	logic [5:0] cur_col_q;
	logic [1:0] cur_row_q;

	logic [2:0] next_row;
	logic       adv_clear;
	logic [7:0] adv_byte;
	logic [1:0] adv_row;
	logic [6:0] next_col;
	logic       wrap;
	logic [6:0] move_addr;
	logic       job_kind;
	logic [5:0] col_d;
	logic [1:0] row_d;

	always_comb begin
		next_row  = {1'b0, cur_row_q} + 3'd1;
		adv_clear = (next_row >= row_count_q) || next_row[2];
		adv_row   = adv_clear ? 2'd0 : next_row[1:0];
		adv_byte  = adv_clear ? CMD_CLEAR : (CMD_DDRAM | {1'b0, row_base(next_row[1:0])});
		next_col  = {1'b0, cur_col_q} + 7'd1;
		wrap      = next_col >= {1'b0, column_count_q};
		// address keeps 7 bits, so large columns wrap
		move_addr = row_base(req.target_row) + {1'b0, req.target_column};
	end

	always_comb begin
		job_kind  = 1'b1;
		job.two   = 1'b0;
		job.rs0   = 1'b0;
		job.byte0 = CMD_CLEAR;
		job.byte1 = adv_byte;
		col_d     = cur_col_q;
		row_d     = cur_row_q;
		case (req.req_type)
			REQ_CHAR: begin
				if (req.char_code == NEWLINE_CODE) begin
					job.byte0 = adv_byte;
					col_d     = 6'd0;
					row_d     = adv_row;
				end else begin
					job.rs0   = 1'b1;
					job.byte0 = req.char_code;
					if (wrap) begin
						job.two = 1'b1;
						col_d   = 6'd0;
						row_d   = adv_row;
					end else begin
						col_d = next_col[5:0];
					end
				end
			end
			REQ_MOVE: begin
				job.byte0 = CMD_DDRAM | {1'b0, move_addr};
				col_d     = req.target_column;
				row_d     = req.target_row;
			end
			REQ_CLEAR: begin
				col_d = 6'd0;
				row_d = 2'd0;
			end
			default: begin
				// unused request type: drop
				job_kind = 1'b0;
			end
		endcase
		job_vld = req_vld && job_kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= ROW_COUNT_RST;
			column_count_q <= COLUMN_COUNT_RST;
			cur_col_q      <= 6'd0;
			cur_row_q      <= 2'd0;
		end else begin
			if (cfg_wr && cfg_index == CFG_ROW_COUNT) begin
				row_count_q <= cfg_data[2:0];
			end
			if (cfg_wr && cfg_index == CFG_COLUMN_COUNT) begin
				column_count_q <= cfg_data[5:0];
			end
			if (job_vld) begin
				cur_col_q <= col_d;
				cur_row_q <= row_d;
			end
		end
	end

endmodule

FILE: src/lcdw_queue.sv
// Short job queue between the front end and the nibble sequencer.
module lcdw_queue import lcdw_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wdata,
	output logic full,
	input  logic rd,
	output logic vld,
	output job_t rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = count_q == CNT_W'(DEPTH);
	assign vld   = count_q != '0;
	assign rdata = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) wr |-> (!full || rd))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) rd |-> vld)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");

endmodule

FILE: src/lcdw_back.sv
// Back end: splits queued bytes into nibbles and holds them in the output register.
module lcdw_back import lcdw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic job_vld,
	input  job_t job,
	output logic job_rd,
	output logic empty,
	input  logic pop,
	output res_t res
);

	logic [1:0] idx_q;
	logic       out_vld_q;
	res_t       res_q;
	res_t       nib;
	logic       load;

	always_comb begin
		case (idx_q)
			2'd0:    nib = '{reg_select: job.rs0, bus_nibble: job.byte0[7:4], last_nibble: 1'b0};
			2'd1:    nib = '{reg_select: job.rs0, bus_nibble: job.byte0[3:0],
			                 last_nibble: !job.two};
			2'd2:    nib = '{reg_select: 1'b0, bus_nibble: job.byte1[7:4], last_nibble: 1'b0};
			2'd3:    nib = '{reg_select: 1'b0, bus_nibble: job.byte1[3:0], last_nibble: 1'b1};
			default: nib = '{reg_select: 1'b0, bus_nibble: 4'd0, last_nibble: 1'b1};
		endcase
		load   = job_vld && (!out_vld_q || pop);
		job_rd = load && nib.last_nibble;
	end

	assign empty = !out_vld_q;
	assign res   = res_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= nib;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= 2'd0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
				idx_q     <= nib.last_nibble ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	a_job_done: assert property (@(posedge clk) disable iff (!arst_n)
		job_rd |=> (idx_q == 2'd0) && res_q.last_nibble)
		else $error("job retired without its last nibble");
	a_idx_single: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q == 2'd2 || idx_q == 2'd3) |-> job_vld && job.two)
		else $error("second byte sequenced for a single-byte job");

endmodule

FILE: src/char_lcd_cursor_nibble_writer_unit.sv
// Top level of the character LCD cursor and 4-bit nibble writer.
// The first nibble of an item reaches the result ports through the job queue and then the output register.
// Throughput: one nibble per cycle from the output register while results are popped and jobs are
// queued; an item gives two or four nibbles, as the front end decides (an unused request type gives
// none), and the job queue holds up to QDEPTH items, the one being split included.
// Reset: cursor goes to row 0 column 0, row_count to 2, column_count to 16, queue empties.
module char_lcd_cursor_nibble_writer_unit import lcdw_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  req_t                  req,
	output logic                  empty,
	input  logic                  pop,
	output res_t                  res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic job_wr;
	job_t job_in;
	logic job_vld;
	job_t job_out;
	logic job_rd;

	assign cfg_ready = 1'b1;

	lcdw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_vld   (push && !full),
		.req       (req),
		.job_vld   (job_wr),
		.job       (job_in)
	);

	lcdw_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_wr),
		.wdata  (job_in),
		.full   (full),
		.rd     (job_rd),
		.vld    (job_vld),
		.rdata  (job_out)
	);

	lcdw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_vld (job_vld),
		.job     (job_out),
		.job_rd  (job_rd),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

endmodule

FILE: verif/char_lcd_cursor_nibble_writer_unit_tb.sv
// Self-checking testbench of the character LCD cursor and nibble writer.
`timescale 1ns / 1ps

module char_lcd_cursor_nibble_writer_unit_tb;
	import lcdw_pkg::*;

	localparam logic [1:0] REQ_UNUSED   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = CFG_IDX_W'(15);
	localparam logic [2:0] BY_PREDICTOR = 3'd7;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         SETTLE       = 8;
	localparam int         PHASES       = 6;
	localparam int         PHASE_ITEMS  = 31;

	typedef enum logic {STEP_ITEM, STEP_CFG} step_kind_t;

	// One row of the directed plan: a request or a register write.
	typedef struct packed {
		step_kind_t            kind;
		req_t                  item;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [2:0]            n_typed;
		res_t                  first_res;
		res_t                  second_res;
	} step_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	req_t                  req;
	logic                  empty;
	logic                  pop;
	res_t                  res;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	char_lcd_cursor_nibble_writer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor state: cursor and the two registers.
	logic [1:0] cur_row;
	logic [5:0] cur_col;
	logic [2:0] rows_cfg;
	logic [5:0] cols_cfg;
	logic [6:0] row_start [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

	res_t burst [$];
	res_t nibble_q [$];
	step_t plan [$];

	int fail_cnt    = 0;
	int cycle_cnt   = 0;
	int tx_idle_pct = 13;
	int rx_idle_pct = 70;
	int rx_hold     = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic res_t nib(input logic rs, input logic [3:0] v, input logic last);
		res_t r;
		r.reg_select  = rs;
		r.bus_nibble  = v;
		r.last_nibble = last;
		return r;
	endfunction

	function automatic req_t rq(input logic [1:0] kind, input logic [7:0] ch,
			input logic [5:0] col, input logic [1:0] row);
		req_t r;
		r.req_type      = kind;
		r.char_code     = ch;
		r.target_column = col;
		r.target_row    = row;
		return r;
	endfunction

	function automatic step_t typed_row(input req_t r, input logic [2:0] n,
			input res_t a, input res_t b);
		step_t s;
		s = '0;
		s.kind       = STEP_ITEM;
		s.item       = r;
		s.n_typed    = n;
		s.first_res  = a;
		s.second_res = b;
		return s;
	endfunction

	function automatic step_t item_row(input req_t r);
		return typed_row(r, BY_PREDICTOR, '0, '0);
	endfunction

	function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		step_t s;
		s = '0;
		s.kind = STEP_CFG;
		s.idx  = idx;
		s.data = val;
		return s;
	endfunction

	task automatic put_byte(input logic rs, input logic [7:0] b);
		burst.push_back(nib(rs, b[7:4], 1'b0));
		burst.push_back(nib(rs, b[3:0], 1'b0));
	endtask

	task automatic put_goto();
		logic [6:0] addr;
		addr = row_start[cur_row] + {1'b0, cur_col};
		put_byte(1'b0, CMD_DDRAM | {1'b0, addr});
	endtask

	task automatic feed_line();
		logic [2:0] nxt;
		nxt = {1'b0, cur_row} + 3'd1;
		cur_col = '0;
		if (nxt >= rows_cfg || nxt >= 3'd4) begin
			cur_row = '0;
			put_byte(1'b0, CMD_CLEAR);
		end else begin
			cur_row = nxt[1:0];
			put_goto();
		end
	endtask

	// Turn one request into its nibble writes and advance the cursor.
	task automatic encode_request(input req_t r);
		logic [6:0] nxt;
		res_t       tail;
		burst.delete();
		case (r.req_type)
			REQ_CHAR: begin
				if (r.char_code == NEWLINE_CODE) begin
					feed_line();
				end else begin
					put_byte(1'b1, r.char_code);
					nxt = {1'b0, cur_col} + 7'd1;
					if (nxt >= {1'b0, cols_cfg})
						feed_line();
					else
						cur_col = nxt[5:0];
				end
			end
			REQ_MOVE: begin
				cur_col = r.target_column;
				cur_row = r.target_row;
				put_goto();
			end
			REQ_CLEAR: begin
				cur_col = '0;
				cur_row = '0;
				put_byte(1'b0, CMD_CLEAR);
			end
			default: ;
		endcase
		if (burst.size() > 0) begin
			tail = burst[burst.size()-1];
			tail.last_nibble = 1'b1;
			burst[burst.size()-1] = tail;
		end
	endtask

	task automatic record_item(input step_t s);
		encode_request(s.item);
		if (s.n_typed == BY_PREDICTOR) begin
			foreach (burst[i])
				nibble_q.push_back(burst[i]);
		end else begin
			if (s.n_typed > 0)
				nibble_q.push_back(s.first_res);
			if (s.n_typed > 1)
				nibble_q.push_back(s.second_res);
		end
	endtask

	// Offer one item and hold it until accepted; push stays high afterwards.
	task automatic send_step(input step_t s);
		push <= 1'b1;
		req  <= s.item;
		@(posedge clk);
		while (full)
			@(posedge clk);
		record_item(s);
	endtask

	task automatic tx_gap();
		if ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			req  <= rq(2'($urandom_range(3)), 8'($urandom_range(255)),
				6'($urandom_range(63)), 2'($urandom_range(3)));
			do
				@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	// Drain all results, then let any result-free item clear the pipeline.
	task automatic settle();
		push <= 1'b0;
		while (nibble_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_ROW_COUNT)
			rows_cfg = val[2:0];
		else if (idx == CFG_COLUMN_COUNT)
			cols_cfg = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic req_t random_req();
		req_t r;
		int   pick;
		r = rq(REQ_CHAR, 8'($urandom_range(255)), 6'($urandom_range(39)),
			2'($urandom_range(3)));
		if ($urandom_range(99) < 15)
			r.target_column = 6'($urandom_range(63));
		pick = $urandom_range(99);
		if (pick < 12)
			r.char_code = NEWLINE_CODE;
		else if (pick < 60)
			r.req_type = REQ_CHAR;
		else if (pick < 82)
			r.req_type = REQ_MOVE;
		else if (pick < 94)
			r.req_type = REQ_CLEAR;
		else
			r.req_type = REQ_UNUSED;
		return r;
	endfunction

	task automatic check_nibble(input res_t got);
		res_t want;
		if (nibble_q.size() == 0) begin
			fail_cnt++;
			if (fail_cnt <= 10)
				$display("unexpected nibble: rs=%0d nibble=%h last=%0d",
					got.reg_select, got.bus_nibble, got.last_nibble);
		end else begin
			want = nibble_q.pop_front();
			if (got.reg_select !== want.reg_select || got.bus_nibble !== want.bus_nibble ||
					got.last_nibble !== want.last_nibble) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("nibble mismatch: expected rs=%0d nibble=%h last=%0d, ",
						"got rs=%0d nibble=%h last=%0d",
						want.reg_select, want.bus_nibble, want.last_nibble,
						got.reg_select, got.bus_nibble, got.last_nibble);
			end
		end
	endtask

	// Result side: check accepted nibbles, then decide pop for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_nibble(res);
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("char_lcd_cursor_nibble_writer_unit verification failed");
			$finish;
		end
	end

	initial begin
		logic [2:0] rows;
		logic [2:0] hi;
		logic [5:0] cols;
		int         ph;
		int         k;

		arst_n    = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		cur_row   = '0;
		cur_col   = '0;
		rows_cfg  = ROW_COUNT_RST;
		cols_cfg  = COLUMN_COUNT_RST;

		// Reset defaults: two rows of sixteen.
		plan.push_back(typed_row(rq(REQ_CLEAR, 8'h00, 6'd0, 2'd0), 3'd2,
			nib(1'b0, 4'h0, 1'b0), nib(1'b0, 4'h1, 1'b1)));
		plan.push_back(typed_row(rq(REQ_CHAR, 8'h41, 6'd0, 2'd0), 3'd2,
			nib(1'b1, 4'h4, 1'b0), nib(1'b1, 4'h1, 1'b1)));
		plan.push_back(item_row(rq(REQ_CHAR, 8'hFF, 6'd0, 2'd0)));
		plan.push_back(item_row(rq(REQ_CHAR, 8'h00, 6'd0, 2'd0)));
		plan.push_back(typed_row(rq(REQ_CHAR, NEWLINE_CODE, 6'd0, 2'd0), 3'd2,
			nib(1'b0, 4'hC, 1'b0), nib(1'b0, 4'h0, 1'b1)));
		plan.push_back(typed_row(rq(REQ_CHAR, NEWLINE_CODE, 6'd0, 2'd0), 3'd2,
			nib(1'b0, 4'h0, 1'b0), nib(1'b0, 4'h1, 1'b1)));
		// Address wraps within seven bits; next character starts past the limit.
		plan.push_back(item_row(rq(REQ_MOVE, 8'h00, 6'd63, 2'd3)));
		plan.push_back(item_row(rq(REQ_CHAR, 8'h55, 6'd0, 2'd0)));
		plan.push_back(typed_row(rq(REQ_UNUSED, 8'hFF, 6'd63, 2'd3), 3'd0, '0, '0));
		plan.push_back(item_row(rq(REQ_MOVE, 8'h00, 6'd15, 2'd0)));
		plan.push_back(item_row(rq(REQ_CHAR, 8'hAA, 6'd0, 2'd0)));
		// No rows: every line advance clears.
		plan.push_back(cfg_row(CFG_ROW_COUNT, 6'd0));
		plan.push_back(item_row(rq(REQ_CHAR, NEWLINE_CODE, 6'd0, 2'd0)));
		plan.push_back(item_row(rq(REQ_CHAR, 8'h30, 6'd0, 2'd0)));
		// Rows above four, zero columns: walk all four rows then clear.
		plan.push_back(cfg_row(CFG_ROW_COUNT, 6'd7));
		plan.push_back(cfg_row(CFG_COLUMN_COUNT, 6'd0));
		for (int c = 8'h31; c <= 8'h34; c++)
			plan.push_back(item_row(rq(REQ_CHAR, 8'(c), 6'd0, 2'd0)));
		plan.push_back(cfg_row(CFG_ROW_COUNT, 6'd4));
		plan.push_back(cfg_row(CFG_COLUMN_COUNT, 6'd40));
		plan.push_back(item_row(rq(REQ_MOVE, 8'h00, 6'd39, 2'd3)));
		plan.push_back(item_row(rq(REQ_CHAR, 8'h7E, 6'd0, 2'd0)));
		plan.push_back(cfg_row(CFG_ROW_COUNT, 6'd1));
		plan.push_back(cfg_row(CFG_COLUMN_COUNT, 6'd1));
		plan.push_back(item_row(rq(REQ_CHAR, 8'h41, 6'd0, 2'd0)));
		plan.push_back(cfg_row(CFG_NONE, 6'h3F));
		plan.push_back(cfg_row(CFG_COLUMN_COUNT, 6'd63));
		plan.push_back(cfg_row(CFG_ROW_COUNT, 6'h3B));
		plan.push_back(item_row(rq(REQ_MOVE, 8'h00, 6'd0, 2'd2)));
		plan.push_back(item_row(rq(REQ_CHAR, NEWLINE_CODE, 6'd0, 2'd0)));
		plan.push_back(typed_row(rq(REQ_CLEAR, 8'hFF, 6'd63, 2'd3), 3'd2,
			nib(1'b0, 4'h0, 1'b0), nib(1'b0, 4'h1, 1'b1)));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CFG) begin
				settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_step(plan[i]);
				tx_gap();
			end
		end

		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph < 2) begin
				tx_idle_pct = 13;
				rx_idle_pct = 70;
			end else if (ph < 4) begin
				tx_idle_pct = 70;
				rx_idle_pct = 13;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			case (ph)
				0: begin
					rows = 3'd4;
					cols = 6'd40;
				end
				1: begin
					rows = 3'd1;
					cols = 6'd1;
				end
				5: begin
					rows = 3'd0;
					cols = 6'd63;
				end
				default: begin
					rows = ($urandom_range(99) < 75) ? 3'($urandom_range(1, 4)) :
						3'($urandom_range(7));
					k = $urandom_range(99);
					cols = (k < 50) ? 6'($urandom_range(1, 8)) :
						(k < 85) ? 6'($urandom_range(1, 40)) : 6'($urandom_range(63));
				end
			endcase
			hi = 3'($urandom_range(7));
			write_reg(CFG_ROW_COUNT, {hi, rows});
			write_reg(CFG_COLUMN_COUNT, cols);
			// Hold the result side off long enough to back up the input.
			if (ph == 4)
				rx_hold = 80;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 3 && k == PHASE_ITEMS / 2) begin
					push <= 1'b0;
					while (nibble_q.size() != 0)
						@(posedge clk);
				end
				send_step(item_row(random_req()));
				tx_gap();
			end
		end

		push <= 1'b0;
		while (nibble_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_cnt == 0 && nibble_q.size() == 0) begin
			$display("char_lcd_cursor_nibble_writer_unit verification clean");
		end else begin
			$display("char_lcd_cursor_nibble_writer_unit verification failed");
		end
		$finish;
	end

endmodule
